/* design/assert_macros.svh */
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every rising clock edge out of reset
`define ASSERT_ALWAYS(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(name, clk, rst_n, cond) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_ALWAYS(name, clk, rst_n, prop)
`define ASSERT_NEVER(name, clk, rst_n, cond)

`endif

`endif

/* design/bmmd_pkg.sv */
package bmmd_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int INDEX_WIDTH = 32;
	localparam int FILL_WIDTH  = 25;

	localparam logic [FILL_WIDTH-1:0] BUCKET_SIZE_RESET = FILL_WIDTH'(4);

	// first, low, high, latest
	localparam int NPTS   = 4;
	localparam int SLOT_W = $clog2(NPTS);

	localparam int Q_PTR_W     = 2;
	localparam int QUEUE_DEPTH = 1 << Q_PTR_W;

	// one closed bucket, fields in first/low/high/latest order
	typedef struct packed {
		logic [NPTS-1:0][INDEX_WIDTH-1:0] ix;
		logic [NPTS-1:0][VALUE_WIDTH-1:0] vx;
		logic                             rf;
	} rec_t;

endpackage

/* design/bucket_min_max_decimator.sv */
// Min/max bucket decimator: one curve sample enters per cycle whenever the bucket record
// queue (4 entries) has room. A bucket that closes on an item writes one record into the
// queue; the back end ranks the record's indices, sorts and drops duplicate indices, then
// sends its 1 to 4 points at one point per cycle while the output is not stalled.
// A closed bucket's record moves from the queue through the rank stage and the sorted
// stage into the output register. Input stalls only when four closed buckets wait.
`include "assert_macros.svh"

module bucket_min_max_decimator import bmmd_pkg::*; (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [FILL_WIDTH-1:0]              cfg_wr_data,   // bucket_size
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [VALUE_WIDTH-1:0]             s_axis_tdata,  // sample_value
	input  logic                               s_axis_tuser,  // sample_valid
	input  logic                               s_axis_tlast,  // end_of_curve
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [INDEX_WIDTH+VALUE_WIDTH-1:0] m_axis_tdata,  // point_index, point_value
	output logic                               m_axis_tuser,  // run_first
	output logic                               m_axis_tlast   // last
);

	logic q_push, q_full, q_pop, q_valid;
	rec_t push_rec, head_rec;
	logic mid_point_taken;

	bmmd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.q_full        (q_full),
		.push          (q_push),
		.push_rec      (push_rec)
	);

	bmmd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_rec   (push_rec),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_rec   (head_rec)
	);

	bmmd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (q_valid),
		.head_rec      (head_rec),
		.pop           (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// a point taken that is not the last of its bucket
	assign mid_point_taken = m_axis_tvalid && m_axis_tready && !m_axis_tlast;

	// record queue must never be written full or read empty
	`ASSERT_NEVER(a_queue_overflow, clk, arst_n, q_push && q_full)
	`ASSERT_NEVER(a_queue_underflow, clk, arst_n, q_pop && !q_valid)
	// a run start mark only ever sits on the first point of a bucket
	`ASSERT_ALWAYS(a_run_first_pos, clk, arst_n, mid_point_taken |=> !(m_axis_tvalid && m_axis_tuser))

endmodule

/* design/bmmd_front.sv */
module bmmd_front import bmmd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [FILL_WIDTH-1:0]  cfg_wr_data,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [VALUE_WIDTH-1:0] s_axis_tdata,
	input  logic                   s_axis_tuser,
	input  logic                   s_axis_tlast,
	input  logic                   q_full,
	output logic                   push,
	output rec_t                   push_rec
);

	logic [FILL_WIDTH-1:0]  bucket_size_q;
	logic [INDEX_WIDTH-1:0] counter_q;
	logic                   in_run_q;
	logic                   pending_q;
	logic [FILL_WIDTH-1:0]  fill_q;
	logic [INDEX_WIDTH-1:0] first_ix_q, low_ix_q, high_ix_q, latest_ix_q;
	logic [VALUE_WIDTH-1:0] first_v_q, low_v_q, high_v_q, latest_v_q;

	logic [INDEX_WIDTH-1:0] first_ix_n, low_ix_n, high_ix_n, latest_ix_n;
	logic [VALUE_WIDTH-1:0] first_v_n, low_v_n, high_v_n, latest_v_n;
	logic [FILL_WIDTH-1:0]  fill0, fill1, fill_n;
	logic                   pend0, pend_n, in_run_n, close, rf;
	logic [INDEX_WIDTH-1:0] counter_n;
	logic                   accept;

	assign s_axis_tready = !q_full;
	assign accept        = s_axis_tvalid && !q_full;

	always_comb begin
		first_ix_n  = first_ix_q;
		low_ix_n    = low_ix_q;
		high_ix_n   = high_ix_q;
		latest_ix_n = latest_ix_q;
		first_v_n   = first_v_q;
		low_v_n     = low_v_q;
		high_v_n    = high_v_q;
		latest_v_n  = latest_v_q;
		fill0       = in_run_q ? fill_q : '0;
		pend0       = in_run_q ? pending_q : 1'b1;
		fill1       = fill0;
		close       = 1'b0;
		rf          = pending_q;
		pend_n      = pending_q;
		in_run_n    = 1'b0;
		fill_n      = '0;
		if (s_axis_tuser) begin
			if (fill0 == '0) begin
				first_ix_n  = counter_q;
				low_ix_n    = counter_q;
				high_ix_n   = counter_q;
				latest_ix_n = counter_q;
				first_v_n   = s_axis_tdata;
				low_v_n     = s_axis_tdata;
				high_v_n    = s_axis_tdata;
				latest_v_n  = s_axis_tdata;
				fill1       = FILL_WIDTH'(1);
			end else begin
				// strict improvement only, earliest extreme wins a tie
				if ($signed(s_axis_tdata) < $signed(low_v_q)) begin
					low_v_n  = s_axis_tdata;
					low_ix_n = counter_q;
				end
				if ($signed(s_axis_tdata) > $signed(high_v_q)) begin
					high_v_n  = s_axis_tdata;
					high_ix_n = counter_q;
				end
				latest_ix_n = counter_q;
				latest_v_n  = s_axis_tdata;
				fill1       = fill0 + FILL_WIDTH'(1);
			end
			close    = (fill1 >= bucket_size_q) || s_axis_tlast;
			rf       = pend0;
			pend_n   = s_axis_tlast ? 1'b1 : (close ? 1'b0 : pend0);
			in_run_n = !s_axis_tlast;
			fill_n   = close ? '0 : fill1;
		end else begin
			close  = in_run_q && (fill_q != '0);
			rf     = pending_q;
			pend_n = in_run_q ? 1'b1 : pending_q;
		end
		counter_n = s_axis_tlast ? '0 : counter_q + INDEX_WIDTH'(1);
	end

	assign push        = accept && close;
	assign push_rec.ix = {latest_ix_n, high_ix_n, low_ix_n, first_ix_n};
	assign push_rec.vx = {latest_v_n, high_v_n, low_v_n, first_v_n};
	assign push_rec.rf = rf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_size_q <= BUCKET_SIZE_RESET;
			counter_q     <= '0;
			in_run_q      <= 1'b0;
			pending_q     <= 1'b1;
			fill_q        <= '0;
			first_ix_q    <= '0;
			low_ix_q      <= '0;
			high_ix_q     <= '0;
			latest_ix_q   <= '0;
			first_v_q     <= '0;
			low_v_q       <= '0;
			high_v_q      <= '0;
			latest_v_q    <= '0;
		end else begin
			if (cfg_wr_en) begin
				bucket_size_q <= cfg_wr_data;
			end
			if (accept) begin
				counter_q   <= counter_n;
				in_run_q    <= in_run_n;
				pending_q   <= pend_n;
				fill_q      <= fill_n;
				first_ix_q  <= first_ix_n;
				low_ix_q    <= low_ix_n;
				high_ix_q   <= high_ix_n;
				latest_ix_q <= latest_ix_n;
				first_v_q   <= first_v_n;
				low_v_q     <= low_v_n;
				high_v_q    <= high_v_n;
				latest_v_q  <= latest_v_n;
			end
		end
	end

endmodule

/* design/bmmd_queue.sv */
module bmmd_queue import bmmd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  rec_t push_rec,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output rec_t head_rec
);

	rec_t               mem_q [QUEUE_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_PTR_W:0]   count_q;

	assign full       = (count_q == (Q_PTR_W+1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_rec   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + (Q_PTR_W+1)'(1);
				2'b01:   count_q <= count_q - (Q_PTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* design/bmmd_back.sv */
module bmmd_back import bmmd_pkg::*; (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 head_valid,
	input  rec_t                                 head_rec,
	output logic                                 pop,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [INDEX_WIDTH+VALUE_WIDTH-1:0]   m_axis_tdata,
	output logic                                 m_axis_tuser,
	output logic                                 m_axis_tlast
);

	// rank stage
	rec_t                        rec_s1;
	logic [NPTS-1:0][SLOT_W-1:0] rank_s1;
	logic                        valid_s1_q;
	// sorted stage, mask holds the points still to send
	logic [NPTS-1:0][INDEX_WIDTH-1:0] idx_s2;
	logic [NPTS-1:0][VALUE_WIDTH-1:0] val_s2;
	logic [NPTS-1:0]                  mask_s2_q;
	logic                             rf_s2;
	// output register
	logic                             out_valid_q;
	logic [INDEX_WIDTH+VALUE_WIDTH-1:0] out_data_q;
	logic                             out_rf_q, out_last_q;

	logic [NPTS-1:0][SLOT_W-1:0]      rank_n;
	logic [NPTS-1:0][INDEX_WIDTH-1:0] sidx_n;
	logic [NPTS-1:0][VALUE_WIDTH-1:0] sval_n;
	logic [NPTS-1:0]                  keep_n;
	logic [SLOT_W-1:0]                sel;
	logic [NPTS-1:0]                  remain;
	logic out_load, emit, final_pt, s2_free, s1_adv, s1_free;

	// stable rank: ties keep first, low, high, latest order
	always_comb begin
		for (int i = 0; i < NPTS; i++) begin
			rank_n[i] = '0;
			for (int j = 0; j < NPTS; j++) begin
				if (j < i) begin
					rank_n[i] = rank_n[i] +
						{{(SLOT_W-1){1'b0}}, head_rec.ix[j] <= head_rec.ix[i]};
				end else if (j > i) begin
					rank_n[i] = rank_n[i] +
						{{(SLOT_W-1){1'b0}}, head_rec.ix[j] < head_rec.ix[i]};
				end
			end
		end
	end

	always_comb begin
		for (int p = 0; p < NPTS; p++) begin
			sidx_n[p] = '0;
			sval_n[p] = '0;
			for (int i = 0; i < NPTS; i++) begin
				if (rank_s1[i] == SLOT_W'(p)) begin
					sidx_n[p] = sidx_n[p] | rec_s1.ix[i];
					sval_n[p] = sval_n[p] | rec_s1.vx[i];
				end
			end
		end
		keep_n[0] = 1'b1;
		for (int p = 1; p < NPTS; p++) begin
			keep_n[p] = (sidx_n[p] != sidx_n[p-1]);
		end
	end

	// lowest pending slot goes out next
	always_comb begin
		sel = '0;
		for (int p = NPTS-1; p >= 0; p--) begin
			if (mask_s2_q[p]) begin
				sel = SLOT_W'(p);
			end
		end
		remain = mask_s2_q & ~(NPTS'(1) << sel);
	end

	assign out_load = !out_valid_q || m_axis_tready;
	assign emit     = (mask_s2_q != '0) && out_load;
	assign final_pt = (remain == '0);
	assign s2_free  = (mask_s2_q == '0) || (emit && final_pt);
	assign s1_adv   = valid_s1_q && s2_free;
	assign s1_free  = !valid_s1_q || s1_adv;
	assign pop      = head_valid && s1_free;

	always_ff @(posedge clk) begin
		if (pop) begin
			rec_s1  <= head_rec;
			rank_s1 <= rank_n;
		end
		if (s1_adv) begin
			idx_s2 <= sidx_n;
			val_s2 <= sval_n;
			rf_s2  <= rec_s1.rf;
		end
		if (emit) begin
			out_data_q <= {val_s2[sel], idx_s2[sel]};
			out_rf_q   <= rf_s2 && (sel == '0);
			out_last_q <= final_pt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q  <= 1'b0;
			mask_s2_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1_q <= head_valid;
			end
			if (s1_adv) begin
				mask_s2_q <= keep_n;
			end else if (emit) begin
				mask_s2_q <= remain;
			end
			if (out_load) begin
				out_valid_q <= emit;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_rf_q;
	assign m_axis_tlast  = out_last_q;

endmodule

/* tb/sv/tb_bucket_min_max_decimator.sv */
`timescale 1ns / 1ps

import bmmd_pkg::*;

typedef struct packed {
	logic [INDEX_WIDTH-1:0]        index;
	logic signed [VALUE_WIDTH-1:0] value;
	logic                          run_first;
	logic                          last;
} point_t;

// how a random run of valid samples is ended
typedef enum int {
	RUN_EOC_ON_SAMPLE,
	RUN_EOC_ON_GAP,
	RUN_GAPS,
	RUN_CONTINUES
} run_end_t;

class bucket_point_predictor;
	logic [FILL_WIDTH-1:0]         bucket_size;
	logic [INDEX_WIDTH-1:0]        next_index;
	bit                            in_run;
	bit                            start_pending;
	logic [FILL_WIDTH-1:0]         fill;
	// first, low, high, latest
	logic [INDEX_WIDTH-1:0]        pick_index[NPTS];
	logic signed [VALUE_WIDTH-1:0] pick_value[NPTS];
	point_t                        fresh_points[$];
	point_t                        awaited_points[$];
	int                            samples_noted;
	int                            points_checked;
	int                            errors;

	function new();
		bucket_size   = BUCKET_SIZE_RESET;
		next_index    = '0;
		in_run        = 1'b0;
		start_pending = 1'b1;
		fill          = '0;
		foreach (pick_index[i]) begin
			pick_index[i] = '0;
			pick_value[i] = '0;
		end
		samples_noted  = 0;
		points_checked = 0;
		errors         = 0;
	endfunction

	function int outstanding();
		return awaited_points.size();
	endfunction

	// ascending distinct indices of the four picks
	function void close_bucket();
		logic [INDEX_WIDTH-1:0]        ix[NPTS];
		logic signed [VALUE_WIDTH-1:0] vx[NPTS];
		logic [INDEX_WIDTH-1:0]        ti;
		logic signed [VALUE_WIDTH-1:0] tv;
		point_t                        p;
		ix = pick_index;
		vx = pick_value;
		for (int i = 1; i < NPTS; i++) begin
			for (int j = i; j > 0 && ix[j-1] > ix[j]; j--) begin
				ti = ix[j]; ix[j] = ix[j-1]; ix[j-1] = ti;
				tv = vx[j]; vx[j] = vx[j-1]; vx[j-1] = tv;
			end
		end
		for (int i = 0; i < NPTS; i++) begin
			if (fresh_points.size() == 0 || fresh_points[fresh_points.size()-1].index != ix[i]) begin
				p.index     = ix[i];
				p.value     = vx[i];
				p.run_first = (fresh_points.size() == 0) && start_pending;
				p.last      = 1'b0;
				fresh_points = {fresh_points, p};
			end
		end
		start_pending = 1'b0;
		fill          = '0;
	endfunction

	function void note_sample(logic signed [VALUE_WIDTH-1:0] v, bit ok, bit eoc);
		logic [INDEX_WIDTH-1:0] idx;
		idx = next_index;
		fresh_points.delete();
		samples_noted++;
		if (ok) begin
			if (!in_run) begin
				in_run        = 1'b1;
				start_pending = 1'b1;
				fill          = '0;
			end
			if (fill == 0) begin
				foreach (pick_index[i]) begin
					pick_index[i] = idx;
					pick_value[i] = v;
				end
				fill = 1;
			end else begin
				// strict improvement only, earliest extreme wins a tie
				if (v < pick_value[1]) begin
					pick_value[1] = v;
					pick_index[1] = idx;
				end
				if (v > pick_value[2]) begin
					pick_value[2] = v;
					pick_index[2] = idx;
				end
				pick_index[3] = idx;
				pick_value[3] = v;
				fill = fill + 1'b1;
			end
			if (fill >= bucket_size || eoc)
				close_bucket();
		end else begin
			if (in_run && fill != 0)
				close_bucket();
			if (in_run)
				start_pending = 1'b1;
			in_run = 1'b0;
			fill   = '0;
		end
		if (eoc) begin
			if (in_run)
				start_pending = 1'b1;
			in_run     = 1'b0;
			fill       = '0;
			next_index = '0;
		end else begin
			next_index = next_index + 1'b1;
		end
		if (fresh_points.size() > 0)
			fresh_points[fresh_points.size()-1].last = 1'b1;
		foreach (fresh_points[i])
			awaited_points = {awaited_points, fresh_points[i]};
	endfunction

	function void check_point(logic [INDEX_WIDTH-1:0] index, logic signed [VALUE_WIDTH-1:0] value,
			bit run_first, bit last);
		point_t want;
		points_checked++;
		if (awaited_points.size() == 0) begin
			$display("%0t: unexpected point index=%0d value=%0d run_first=%0b last=%0b",
				$time, index, value, run_first, last);
			errors++;
			return;
		end
		want = awaited_points.pop_front();
		if (want.index != index || want.value != value || want.run_first != run_first ||
				want.last != last) begin
			$display("%0t: point mismatch, expected index=%0d value=%0d run_first=%0b last=%0b",
				$time, want.index, want.value, want.run_first, want.last);
			$display("%0t:                   actual index=%0d value=%0d run_first=%0b last=%0b",
				$time, index, value, run_first, last);
			errors++;
		end
	endfunction
endclass

module tb_bucket_min_max_decimator;

	localparam int SETTLE_CYCLES  = 10;
	localparam int WATCHDOG_LIMIT = 2000;

	logic                               clk;
	logic                               arst_n = 1'b0;
	logic                               cfg_wr_en = 1'b0;
	logic [FILL_WIDTH-1:0]              cfg_wr_data = '0;
	logic                               s_axis_tvalid = 1'b0;
	logic                               s_axis_tready;
	logic [VALUE_WIDTH-1:0]             s_axis_tdata = '0;   // sample_value
	logic                               s_axis_tuser = 1'b0; // sample_valid
	logic                               s_axis_tlast = 1'b0; // end_of_curve
	logic                               m_axis_tvalid;
	logic                               m_axis_tready = 1'b0;
	logic [INDEX_WIDTH+VALUE_WIDTH-1:0] m_axis_tdata;        // point_index, point_value
	logic                               m_axis_tuser;        // run_first
	logic                               m_axis_tlast;        // last

	bucket_point_predictor predictor = new();
	bit idle_en = 1'b1;
	int sent_samples = 0;
	int sizes_written = 0;
	int quiet_cycles = 0;
	int sink_hold = 0;

	bucket_min_max_decimator uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// both handshakes sampled in one process so an item is noted before any point it causes
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				predictor.note_sample(s_axis_tdata, s_axis_tuser, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready)
				predictor.check_point(m_axis_tdata[INDEX_WIDTH-1:0],
					m_axis_tdata[INDEX_WIDTH+VALUE_WIDTH-1:INDEX_WIDTH], m_axis_tuser, m_axis_tlast);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// output stalls in random bursts, only while idle_en is set
	always @(posedge clk) begin
		if (sink_hold > 0) begin
			m_axis_tready <= 1'b0;
			sink_hold--;
		end else if (idle_en && $urandom_range(0, 5) == 0) begin
			m_axis_tready <= 1'b0;
			sink_hold = $urandom_range(0, 9);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic put_sample(input logic [VALUE_WIDTH-1:0] v, input bit ok, input bit eoc);
		if (idle_en && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= v;
		s_axis_tuser  <= ok;
		s_axis_tlast  <= eoc;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sent_samples++;
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (predictor.outstanding() != 0)
			@(posedge clk);
		// an item with no points may still be in flight
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_bucket_size(input logic [FILL_WIDTH-1:0] size_val);
		wait_drained();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= size_val;
		@(posedge clk);
		predictor.bucket_size = size_val;
		cfg_wr_en <= 1'b0;
		sizes_written++;
	endtask

	function automatic logic [VALUE_WIDTH-1:0] rand_value();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			// narrow range so ties come often
			2, 3: return VALUE_WIDTH'($urandom_range(0, 6)) - VALUE_WIDTH'(3);
			default: return $urandom;
		endcase
	endfunction

	task automatic random_stream(input int count);
		int       target;
		int       run_len;
		run_end_t how;
		target = sent_samples + count;
		while (sent_samples < target) begin
			run_len = $urandom_range(1, 12);
			how     = run_end_t'($urandom_range(0, 3));
			for (int k = 0; k < run_len && sent_samples < target; k++)
				put_sample(rand_value(), 1'b1, how == RUN_EOC_ON_SAMPLE && k == run_len - 1);
			case (how)
				RUN_EOC_ON_GAP: put_sample($urandom, 1'b0, 1'b1);
				RUN_GAPS: begin
					repeat ($urandom_range(1, 3))
						put_sample($urandom, 1'b0, 1'b0);
				end
				default: ;
			endcase
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset bucket size of four
		put_sample(32'h7FFF_FFFF, 1'b1, 1'b0);
		put_sample(32'h8000_0000, 1'b1, 1'b0);
		put_sample(32'h0000_0000, 1'b1, 1'b0);
		put_sample(32'hFFFF_FFFF, 1'b1, 1'b0);
		// flat bucket, second bucket of the same run
		repeat (4) put_sample(32'd5, 1'b1, 1'b0);
		put_sample(32'h1234_5678, 1'b0, 1'b0);
		// one-sample bucket closed by a gap, then a gap outside any run
		put_sample(32'd100, 1'b1, 1'b0);
		put_sample(32'hDEAD_BEEF, 1'b0, 1'b0);
		put_sample(32'h0000_0001, 1'b0, 1'b0);
		put_sample(-32'sd7, 1'b1, 1'b1);
		// falling run ended by the curve end
		put_sample(32'd3, 1'b1, 1'b0);
		put_sample(32'd2, 1'b1, 1'b0);
		put_sample(32'd1, 1'b1, 1'b1);
		// curve end on a gap, inside and outside a run
		put_sample(32'd10, 1'b1, 1'b0);
		put_sample(32'd20, 1'b1, 1'b0);
		put_sample(32'hFFFF_0000, 1'b0, 1'b1);
		put_sample(32'h0000_FFFF, 1'b0, 1'b1);
		// ties at both extremes keep the earliest sample
		put_sample(32'h8000_0000, 1'b1, 1'b0);
		put_sample(32'h8000_0000, 1'b1, 1'b0);
		put_sample(32'h7FFF_FFFF, 1'b1, 1'b0);
		put_sample(32'h7FFF_FFFF, 1'b1, 1'b0);

		write_bucket_size(FILL_WIDTH'(2));
		random_stream(40);
		// sizes below two close a bucket on every sample
		write_bucket_size(FILL_WIDTH'(1));
		random_stream(30);
		write_bucket_size(FILL_WIDTH'(0));
		random_stream(20);
		write_bucket_size(FILL_WIDTH'(16777216));
		random_stream(45);
		write_bucket_size(FILL_WIDTH'(3));
		random_stream(40);
		write_bucket_size(FILL_WIDTH'(7));
		random_stream(40);
		write_bucket_size(FILL_WIDTH'($urandom_range(2, 6)));
		idle_en = 1'b0;
		random_stream(45);

		wait_drained();
		$display("sent %0d samples across %0d bucket sizes (0, 1, 2 and 2^24 among them)",
			sent_samples, sizes_written + 1);
		$display("checked %0d decimated points, %0d mismatches",
			predictor.points_checked, predictor.errors);
		if (predictor.errors == 0 && predictor.outstanding() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

/* files.f */
+incdir+design
design/bmmd_pkg.sv
design/bmmd_front.sv
design/bmmd_queue.sv
design/bmmd_back.sv
design/bucket_min_max_decimator.sv
tb/sv/tb_bucket_min_max_decimator.sv
